/* design/fpa_pkg.sv */
// package for the fixed-point alu: types, constants and op codes
`default_nettype none
package fpa_pkg;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned DivWidth = 64;
  localparam int unsigned DivStages = 64;
  localparam int unsigned MulWidth = 64;

  typedef enum logic [1:0] {
    OpAdd = 2'd0,
    OpSub = 2'd1,
    OpMul = 2'd2,
    OpDiv = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    RegIntBits  = 2'd0,
    RegFracBits = 2'd1
  } reg_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
  } fpa_in_t;

  typedef struct packed {
    logic [31:0] result;
    logic        div_by_zero;
  } fpa_out_t;

  // per-item control that travels down the pipeline with the data
  typedef struct packed {
    logic        vld;
    op_e         op;
    logic        neg;
    logic        dz;
    logic [4:0]  fb;
    logic [31:0] mask;
  } fpa_ctl_t;
endpackage
`default_nettype wire

/* design/fpa_div.sv */
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module fpa_div import fpa_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fpa_ctl_t             ctl_i,
  input  logic [DivWidth-1:0]  num_i,
  input  logic [DataWidth-1:0] den_i,
  input  logic [DataWidth-1:0] pass_i,
  output fpa_ctl_t             ctl_o,
  output logic [DivWidth-1:0]  quo_o,
  output logic [DataWidth-1:0] pass_o
);
  fpa_ctl_t             ctl_q [DivStages];
  logic [DivWidth-1:0]  num_q [DivStages];
  logic [DataWidth:0]   rem_q [DivStages];
  logic [DataWidth-1:0] den_q [DivStages];
  logic [DataWidth-1:0] pas_q [DivStages];

  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    fpa_ctl_t             ctl_in;
    logic [DivWidth-1:0]  num_in;
    logic [DataWidth:0]   rem_in;
    logic [DataWidth-1:0] den_in;
    logic [DataWidth-1:0] pas_in;
    logic [DataWidth+1:0] trial_d;
    logic [DataWidth:0]   shr_d;
    // first stage takes the ports, the rest the previous stage
    if (s == 0) begin : g_first
      assign ctl_in = ctl_i;
      assign num_in = num_i;
      assign rem_in = '0;
      assign den_in = den_i;
      assign pas_in = pass_i;
    end else begin : g_next
      assign ctl_in = ctl_q[s-1];
      assign num_in = num_q[s-1];
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign pas_in = pas_q[s-1];
    end
    always_comb begin
      shr_d   = {rem_in[DataWidth-1:0], num_in[DivWidth-1]};
      trial_d = {1'b0, shr_d} - {2'b0, den_in};
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[s] <= '0;
        num_q[s] <= '0;
        rem_q[s] <= '0;
        den_q[s] <= '0;
        pas_q[s] <= '0;
      end else begin
        ctl_q[s] <= ctl_in;
        den_q[s] <= den_in;
        pas_q[s] <= pas_in;
        if (!trial_d[DataWidth+1]) begin
          rem_q[s] <= trial_d[DataWidth:0];
          num_q[s] <= {num_in[DivWidth-2:0], 1'b1};
        end else begin
          rem_q[s] <= shr_d;
          num_q[s] <= {num_in[DivWidth-2:0], 1'b0};
        end
      end
    end
  end

  assign ctl_o  = ctl_q[DivStages-1];
  assign quo_o  = num_q[DivStages-1];
  assign pass_o = pas_q[DivStages-1];
endmodule
`default_nettype wire

/* design/fixed_point_alu_core.sv */
// top level of the fixed-point alu core
// Fixed-point ALU in Q int_bits.frac_bits format, width W = int+frac, at most 32.
// An operation is taken with start whenever busy is low; busy is always
// low, so one operation can enter in every cycle. Every operation, of any kind,
// passes from the transfer to its result strobe (done_o) through the same pipe:
// operand, arithmetic and shift stages, a 64-stage restoring divider and a final
// result register; add, subtract and multiply ride it too so results leave in order.
// The receiver cannot stall, and each result is valid only in its strobe cycle.
`default_nettype none
module fixed_point_alu_core import fpa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  fpa_in_t     op_i,
  output logic        done_o,
  output fpa_out_t    res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [5:0] int_bits_q;
  logic [4:0] frac_bits_q;

  assign pready = 1'b1;
  assign busy   = 1'b0;

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_bits_q  <= 6'd16;
      frac_bits_q <= 5'd16;
    end else if (psel && penable && pwrite) begin
      case (reg_e'(paddr[2]))
        RegIntBits:  int_bits_q  <= pwdata[5:0];
        RegFracBits: frac_bits_q <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_e'(paddr[2]))
      RegIntBits:  prdata = {26'b0, int_bits_q};
      RegFracBits: prdata = {27'b0, frac_bits_q};
      default:     prdata = '0;
    endcase
  end

  // format decode: clip int bits to 1..32-fb
  logic [5:0]  ib_d;
  logic [5:0]  w_d;
  logic [31:0] mask_d;
  always_comb begin
    ib_d = int_bits_q;
    if (ib_d == 6'd0) ib_d = 6'd1;
    if (ib_d > 6'd32 - {1'b0, frac_bits_q}) ib_d = 6'd32 - {1'b0, frac_bits_q};
    w_d = ib_d + {1'b0, frac_bits_q};
    mask_d = 32'hFFFF_FFFF >> (6'd32 - w_d);
  end

  // stage 1: mask operands, magnitudes and signs
  fpa_ctl_t    s1_ctl_q;
  logic [31:0] s1_a_q, s1_b_q, s1_ma_q, s1_mb_q;
  logic [31:0] a_d, b_d, ma_d, mb_d;
  logic        sa_d, sb_d;
  always_comb begin
    a_d  = op_i.operand_a & mask_d;
    b_d  = op_i.operand_b & mask_d;
    sa_d = a_d[5'(w_d - 6'd1)];
    sb_d = b_d[5'(w_d - 6'd1)];
    ma_d = sa_d ? ((~a_d + 32'd1) & mask_d) : a_d;
    mb_d = sb_d ? ((~b_d + 32'd1) & mask_d) : b_d;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctl_q <= '0;
    end else begin
      s1_ctl_q.vld  <= start;
      s1_ctl_q.op   <= op_e'(op_i.kind);
      s1_ctl_q.neg  <= sa_d ^ sb_d;
      s1_ctl_q.dz   <= (b_d == '0);
      s1_ctl_q.fb   <= frac_bits_q;
      s1_ctl_q.mask <= mask_d;
    end
  end
  always_ff @(posedge clk_i) begin
    s1_a_q  <= a_d;
    s1_b_q  <= b_d;
    s1_ma_q <= ma_d;
    s1_mb_q <= mb_d;
  end

  // stage 2: add/sub, multiply, dividend shift
  fpa_ctl_t      s2_ctl_q;
  logic [31:0]   s2_as_q;
  logic [63:0]   s2_prod_q;
  logic [63:0]   s2_num_q;
  logic [31:0]   s2_den_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_ctl_q <= '0;
    else         s2_ctl_q <= s1_ctl_q;
  end
  always_ff @(posedge clk_i) begin
    s2_as_q   <= (s1_ctl_q.op == OpSub) ? (s1_a_q - s1_b_q) : (s1_a_q + s1_b_q);
    s2_prod_q <= {32'b0, s1_ma_q} * {32'b0, s1_mb_q};
    s2_num_q  <= {32'b0, s1_ma_q} << s1_ctl_q.fb;
    s2_den_q  <= s1_mb_q;
  end

  // stage 3: shift product, pick pass value for non-divide ops
  fpa_ctl_t    s3_ctl_q;
  logic [31:0] s3_pass_q;
  logic [63:0] s3_num_q;
  logic [31:0] s3_den_q;
  logic [63:0] prod_sh_d;
  assign prod_sh_d = s2_prod_q >> s2_ctl_q.fb;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_ctl_q <= '0;
    else         s3_ctl_q <= s2_ctl_q;
  end
  always_ff @(posedge clk_i) begin
    s3_pass_q <= (s2_ctl_q.op == OpMul) ? prod_sh_d[31:0] : s2_as_q;
    s3_num_q  <= s2_num_q;
    s3_den_q  <= (s2_den_q == '0) ? 32'd1 : s2_den_q;
  end

  // 64-stage divider, every op flows through it
  fpa_ctl_t    dv_ctl;
  logic [63:0] dv_quo;
  logic [31:0] dv_pass;
  fpa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (s3_ctl_q),
    .num_i  (s3_num_q),
    .den_i  (s3_den_q),
    .pass_i (s3_pass_q),
    .ctl_o  (dv_ctl),
    .quo_o  (dv_quo),
    .pass_o (dv_pass)
  );

  // final stage: mask, sign, zero-divisor
  logic [31:0] mag_d, fin_d;
  logic        dz_d;
  always_comb begin
    dz_d  = 1'b0;
    mag_d = '0;
    fin_d = '0;
    case (dv_ctl.op)
      OpAdd, OpSub: fin_d = dv_pass & dv_ctl.mask;
      OpMul: begin
        mag_d = dv_pass & dv_ctl.mask;
        fin_d = dv_ctl.neg ? ((~mag_d + 32'd1) & dv_ctl.mask) : mag_d;
      end
      OpDiv: begin
        mag_d = dv_quo[31:0] & dv_ctl.mask;
        dz_d  = dv_ctl.dz;
        if (dv_ctl.dz) fin_d = '0;
        else fin_d = dv_ctl.neg ? ((~mag_d + 32'd1) & dv_ctl.mask) : mag_d;
      end
      default: fin_d = '0;
    endcase
  end

  logic     done_q;
  fpa_out_t res_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= dv_ctl.vld;
  end
  always_ff @(posedge clk_i) begin
    res_q.result      <= fin_d;
    res_q.div_by_zero <= dz_d;
  end
  assign done_o = done_q;
  assign res_o  = res_q;
endmodule
`default_nettype wire
